>>> rtl/mpf_pkg.sv
// package for the lock pool with fifo hand-off: sizes, codes, command and status structs
// used by mpf_ctrl, mpf_dp and mutex_pool_fifo_handoff_unit; depends on nothing
package mpf_pkg;

   localparam int NUM_LOCKS = 16;
   localparam int NUM_TASKS = 16;

   // fixed field widths of the stream words
   localparam int MODE_W   = 3;
   localparam int HANDLE_W = 5;
   localparam int TASK_W   = 4;
   localparam int STATUS_W = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam int SLOT_W  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int RIDX_W  = $clog2(NUM_TASKS);
   localparam int CNT_W   = $clog2(NUM_TASKS + 1);
   localparam int OWNER_W = $clog2(NUM_TASKS + 2);
   localparam int RADDR_W = SLOT_W + RIDX_W;
   localparam int RING_DEPTH = 2 ** RADDR_W;

   // owner codes beyond the task ids
   localparam logic [OWNER_W-1:0] NOT_A_TASK = OWNER_W'(NUM_TASKS);
   localparam logic [OWNER_W-1:0] NO_OWNER   = OWNER_W'(NUM_TASKS + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE  = 3'd0,
      MODE_LOCK    = 3'd1,
      MODE_UNLOCK  = 3'd2,
      MODE_CANCEL  = 3'd3,
      MODE_DESTROY = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 4'd0,
      ST_BAD_HANDLE    = 4'd1,
      ST_TIMEOUT       = 4'd2,
      ST_ALREADY_OWNER = 4'd3,
      ST_NOT_LOCKED    = 4'd4,
      ST_NOT_OWNER     = 4'd5,
      ST_QUEUED        = 4'd6,
      ST_POOL_FULL     = 4'd7,
      ST_IN_USE        = 4'd8
   } status_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic scan;
      logic handoff;
      logic drop_rd;
      logic drop_wr;
      logic finish;
   } mpf_cmd_type;

   typedef struct packed {
      logic create;
      logic handoff;
      logic drop;
      logic scan_hit;
      logic scan_last;
      logic drop_last;
   } mpf_stat_type;

   function automatic logic [RIDX_W-1:0] ring_inc(input logic [RIDX_W-1:0] idx);
      logic [RIDX_W-1:0] nxt;
      nxt = (32'(idx) == NUM_TASKS - 1) ? '0 : idx + 1'b1;
      return nxt;
   endfunction

endpackage

>>> rtl/mutex_pool_fifo_handoff_unit.sv
// top level of the lock pool with fifo hand-off: stream ports, controller and datapath
// depends on mpf_pkg, mpf_ctrl and mpf_dp
//
//  channel | dir | payload
//  req     | in  | tuser: mode; tdata: lock_handle, requester_task, requester_is_task
//  rsp     | out | tdata: status, new_handle, wake_valid, wake_task
//
// a word passes accept, decode and result for lock, unlock, destroy and errors;
// an unlock that hands off adds one registered ring memory read,
// create adds a free slot scan (one slot a cycle, up to NUM_LOCKS slots),
// cancel adds ring compaction (read then write per queued waiter).
// reset clears the slot-in-use bits and the handshake state only; no clearing pass.
// a waiting result does not block the next accept; the following result holds until taken.
module mutex_pool_fifo_handoff_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mpf_pkg::REQ_DATA_W-1:0]    req_tdata,  // lock_handle, requester_task, requester_is_task
   input  logic [mpf_pkg::MODE_W-1:0]        req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mpf_pkg::RSP_DATA_W-1:0]    rsp_tdata   // status, new_handle, wake_valid, wake_task
);
   import mpf_pkg::*;

   mpf_cmd_type         cmd;
   mpf_stat_type        stat;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] new_handle;
   logic                wake_valid;
   logic [TASK_W-1:0]   wake_task;

   mpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpf_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .req_mode              (req_tuser),
      .req_lock_handle       (req_tdata[HANDLE_W-1:0]),
      .req_requester_task    (req_tdata[HANDLE_W+TASK_W-1:HANDLE_W]),
      .req_requester_is_task (req_tdata[HANDLE_W+TASK_W]),
      .cmd                   (cmd),
      .stat                  (stat),
      .rsp_status            (status),
      .rsp_new_handle        (new_handle),
      .rsp_wake_valid        (wake_valid),
      .rsp_wake_task         (wake_task)
   );

   assign rsp_tdata = {(RSP_DATA_W - STATUS_W - HANDLE_W - 1 - TASK_W)'(0),
                       wake_task, wake_valid, new_handle, status};

endmodule

>>> rtl/mpf_ctrl.sv
// controller for the lock pool: sequences decode, slot scan, hand-off read,
// queue compaction and the result word handshake; uses mpf_pkg
module mpf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mpf_pkg::mpf_stat_type stat,
   output mpf_pkg::mpf_cmd_type  cmd
);
   import mpf_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_DECODE  = 7'b0000010,
      S_SCAN    = 7'b0000100,
      S_HANDOFF = 7'b0001000,
      S_DROP_RD = 7'b0010000,
      S_DROP_WR = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.exec = 1'b1;
            priority if (stat.create) state_in = S_SCAN;
            else if (stat.handoff)    state_in = S_HANDOFF;
            else if (stat.drop)       state_in = S_DROP_RD;
            else                      state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_last) state_in = S_DONE;
         end
         S_HANDOFF: begin
            cmd.handoff = 1'b1;
            state_in    = S_DONE;
         end
         S_DROP_RD: begin
            cmd.drop_rd = 1'b1;
            state_in    = S_DROP_WR;
         end
         S_DROP_WR: begin
            cmd.drop_wr = 1'b1;
            state_in    = stat.drop_last ? S_DONE : S_DROP_RD;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result word stays until taken
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DECODE))
      else $error("accepted word did not move to decode");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_drop_pairs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DROP_WR) |-> $past(state_ff == S_DROP_RD))
      else $error("compaction write without preceding read");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.finish)
      else $error("pending result overwritten");

endmodule

>>> rtl/mpf_dp.sv
// datapath for the lock pool: slot table, per-slot ring pointers, waiter ring
// memory, request and result registers; uses mpf_pkg, driven by mpf_ctrl
module mpf_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mpf_pkg::MODE_W-1:0]      req_mode,
   input  logic [mpf_pkg::HANDLE_W-1:0]    req_lock_handle,
   input  logic [mpf_pkg::TASK_W-1:0]      req_requester_task,
   input  logic                            req_requester_is_task,
   input  mpf_pkg::mpf_cmd_type            cmd,
   output mpf_pkg::mpf_stat_type           stat,
   output logic [mpf_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mpf_pkg::HANDLE_W-1:0]    rsp_new_handle,
   output logic                            rsp_wake_valid,
   output logic [mpf_pkg::TASK_W-1:0]      rsp_wake_task
);
   import mpf_pkg::*;

   // request word
   logic [MODE_W-1:0]   mode_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [TASK_W-1:0]   task_ff;
   logic                is_task_ff;

   // slot table
   logic                in_use_ff [NUM_LOCKS];
   logic [OWNER_W-1:0]  owner_ff  [NUM_LOCKS];
   logic [RIDX_W-1:0]   head_ff   [NUM_LOCKS];
   logic [RIDX_W-1:0]   tail_ff   [NUM_LOCKS];
   logic [CNT_W-1:0]    count_ff  [NUM_LOCKS];

   // waiter ring memory
   logic [RIDX_W-1:0]   ring_mem  [RING_DEPTH];
   logic [RIDX_W-1:0]   ring_rdata_ff;
   logic                ring_we, ring_re;
   logic [RADDR_W-1:0]  ring_waddr, ring_raddr;
   logic [RIDX_W-1:0]   ring_wdata;

   // scan and compaction
   logic [SLOT_W-1:0]   scan_idx_ff;
   logic [RIDX_W-1:0]   rd_ptr_ff, wr_ptr_ff;
   logic [CNT_W-1:0]    seen_ff, kept_ff;

   // working result and output word
   logic [STATUS_W-1:0] res_status_ff, out_status_ff;
   logic [HANDLE_W-1:0] res_handle_ff, out_handle_ff;
   logic                res_wv_ff, out_wv_ff;
   logic [TASK_W-1:0]   res_wt_ff, out_wt_ff;

   // decode of the held request
   logic [SLOT_W-1:0]   slot;
   logic                hvalid;
   logic [OWNER_W-1:0]  self_id;
   logic [OWNER_W-1:0]  owner_cur;
   logic [CNT_W-1:0]    count_cur;
   logic                push_ok, destroy_ok, keep;

   assign slot      = SLOT_W'(handle_ff - HANDLE_W'(1));
   assign hvalid    = (handle_ff != '0) && (32'(handle_ff) <= NUM_LOCKS) && in_use_ff[slot];
   assign self_id   = (is_task_ff && (32'(task_ff) < NUM_TASKS)) ? OWNER_W'(task_ff)
                                                                 : NOT_A_TASK;
   assign owner_cur = owner_ff[slot];
   assign count_cur = count_ff[slot];
   assign keep      = (ring_rdata_ff != RIDX_W'(self_id));

   assign push_ok = cmd.exec && (mode_ff == MODE_LOCK) && hvalid && (owner_cur != NO_OWNER)
                    && (self_id != NOT_A_TASK) && (owner_cur != self_id)
                    && (count_cur < CNT_W'(NUM_TASKS));
   assign destroy_ok = cmd.exec && (mode_ff == MODE_DESTROY) && hvalid
                       && (owner_cur == NO_OWNER) && (count_cur == '0);

   assign stat.create    = (mode_ff == MODE_CREATE);
   assign stat.handoff   = (mode_ff == MODE_UNLOCK) && hvalid && (owner_cur != NO_OWNER)
                           && (owner_cur == self_id) && (count_cur != '0);
   assign stat.drop      = (mode_ff == MODE_CANCEL) && hvalid && (self_id != NOT_A_TASK)
                           && (count_cur != '0);
   assign stat.scan_hit  = !in_use_ff[scan_idx_ff];
   assign stat.scan_last = (32'(scan_idx_ff) == NUM_LOCKS - 1);
   assign stat.drop_last = (seen_ff == count_cur);

   // ring port selection
   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = {slot, tail_ff[slot]};
      ring_wdata = RIDX_W'(self_id);
      ring_re    = 1'b0;
      ring_raddr = {slot, head_ff[slot]};
      if (push_ok) begin
         ring_we = 1'b1;
      end else if (cmd.drop_wr && keep) begin
         ring_we    = 1'b1;
         ring_waddr = {slot, wr_ptr_ff};
         ring_wdata = ring_rdata_ff;
      end
      if (cmd.exec && stat.handoff) begin
         ring_re = 1'b1;
      end else if (cmd.drop_rd) begin
         ring_re    = 1'b1;
         ring_raddr = {slot, rd_ptr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
      if (ring_re) ring_rdata_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LOCKS; i++) in_use_ff[i] <= 1'b0;
      end else begin
         if (cmd.scan && stat.scan_hit) in_use_ff[scan_idx_ff] <= 1'b1;
         if (destroy_ok) in_use_ff[slot] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff    <= req_mode;
         handle_ff  <= req_lock_handle;
         task_ff    <= req_requester_task;
         is_task_ff <= req_requester_is_task;
      end

      if (cmd.exec) begin
         res_handle_ff <= '0;
         res_wv_ff     <= 1'b0;
         res_wt_ff     <= '0;
         scan_idx_ff   <= '0;
         rd_ptr_ff     <= head_ff[slot];
         wr_ptr_ff     <= head_ff[slot];
         seen_ff       <= '0;
         kept_ff       <= '0;
         if (mode_ff == MODE_CREATE) begin
            res_status_ff <= ST_POOL_FULL;
         end else if (!hvalid) begin
            res_status_ff <= ST_BAD_HANDLE;
         end else begin
            unique case (mode_ff)
               MODE_LOCK: begin
                  priority if (owner_cur == NO_OWNER) begin
                     owner_ff[slot] <= self_id;
                     res_status_ff  <= ST_OK;
                  end else if (self_id == NOT_A_TASK) begin
                     res_status_ff <= ST_TIMEOUT;
                  end else if (owner_cur == self_id) begin
                     res_status_ff <= ST_ALREADY_OWNER;
                  end else begin
                     // a full queue drops the push but still reports queued
                     if (push_ok) begin
                        tail_ff[slot]  <= ring_inc(tail_ff[slot]);
                        count_ff[slot] <= count_cur + 1'b1;
                     end
                     res_status_ff <= ST_QUEUED;
                  end
               end
               MODE_UNLOCK: begin
                  priority if (owner_cur == NO_OWNER) begin
                     res_status_ff <= ST_NOT_LOCKED;
                  end else if (owner_cur != self_id) begin
                     res_status_ff <= ST_NOT_OWNER;
                  end else begin
                     res_status_ff <= ST_OK;
                     if (count_cur == '0) owner_ff[slot] <= NO_OWNER;
                  end
               end
               MODE_CANCEL: res_status_ff <= ST_TIMEOUT;
               MODE_DESTROY: begin
                  res_status_ff <= destroy_ok ? ST_OK : ST_IN_USE;
               end
               default: res_status_ff <= ST_BAD_HANDLE;
            endcase
         end
      end

      if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (stat.scan_hit) begin
            owner_ff[scan_idx_ff] <= NO_OWNER;
            head_ff[scan_idx_ff]  <= '0;
            tail_ff[scan_idx_ff]  <= '0;
            count_ff[scan_idx_ff] <= '0;
            res_status_ff         <= ST_OK;
            res_handle_ff         <= HANDLE_W'(scan_idx_ff) + 1'b1;
         end
      end

      if (cmd.handoff) begin
         owner_ff[slot] <= OWNER_W'(ring_rdata_ff);
         head_ff[slot]  <= ring_inc(head_ff[slot]);
         count_ff[slot] <= count_cur - 1'b1;
         res_wv_ff      <= 1'b1;
         res_wt_ff      <= TASK_W'(ring_rdata_ff);
      end

      if (cmd.drop_rd) begin
         rd_ptr_ff <= ring_inc(rd_ptr_ff);
         seen_ff   <= seen_ff + 1'b1;
      end

      if (cmd.drop_wr) begin
         if (keep) begin
            wr_ptr_ff <= ring_inc(wr_ptr_ff);
            kept_ff   <= kept_ff + 1'b1;
         end
         if (stat.drop_last) begin
            tail_ff[slot]  <= keep ? ring_inc(wr_ptr_ff) : wr_ptr_ff;
            count_ff[slot] <= kept_ff + CNT_W'(keep);
         end
      end

      if (cmd.finish) begin
         out_status_ff <= res_status_ff;
         out_handle_ff <= res_handle_ff;
         out_wv_ff     <= res_wv_ff;
         out_wt_ff     <= res_wt_ff;
      end
   end

   assign rsp_status     = out_status_ff;
   assign rsp_new_handle = out_handle_ff;
   assign rsp_wake_valid = out_wv_ff;
   assign rsp_wake_task  = out_wt_ff;

   a_one_ring_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec && ring_we && ring_re))
      else $error("push and hand-off read in the same decode");

   a_handoff_has_waiter: assert property (@(posedge clock) disable iff (reset)
      cmd.handoff |-> (count_cur != '0))
      else $error("hand-off from an empty queue");

endmodule
